// ----- rtl/lpd_pkg.sv -----
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants of the length-prefixed packet deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

  localparam int unsigned STORE_DEPTH = 32;
  localparam int unsigned STORE_AW = 5;
  localparam logic [15:0] MAX_LEN_RESET = 16'd29000;

  typedef enum logic [1:0] {
    ST_HUNT,
    ST_CHECK,
    ST_REPLAY,
    ST_BODY
  } state_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        is_header;
    logic        last;
    logic        rejected;
    logic [15:0] packet_length;
  } result_t;

endpackage

// ----- rtl/lpd_ram.sv -----
// ----------------------------------------------------------------------------
// lpd_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lpd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/lpd_out_stage.sv -----
// ----------------------------------------------------------------------------
// lpd_out_stage
// Output register of the deframer: holds one result item until taken.
// ----------------------------------------------------------------------------
module lpd_out_stage
  import lpd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res_in,
  output logic    free,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t res_out
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

// ----- rtl/length_prefixed_packet_deframer.sv -----
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer
// Body bytes: one per cycle while the output slot is free, result the cycle after.
// Header: HEAD_LEN items at one per cycle into the header RAM, the length
// check (a reject gives one rejected item), then HEAD_LEN items replayed from
// the registered RAM read at one per cycle while the output slot is free.
// Reset (rst, synchronous): hunts a header, max length 29000; RAM not cleared.
// ----------------------------------------------------------------------------
module length_prefixed_packet_deframer
  import lpd_pkg::*;
#(
  parameter int unsigned HEAD_LEN = 8,
  parameter int unsigned LEN_OFFSET = 0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_is_header,
  output logic        out_last,
  output logic        out_rejected,
  output logic [15:0] out_packet_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] max_packet_length
);

  localparam int unsigned CNT_W = $clog2(HEAD_LEN + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(HEAD_LEN - 1);
  localparam logic [CNT_W-1:0] CNT_DONE = CNT_W'(HEAD_LEN);
  localparam logic [5:0] OFF_HI = 6'(LEN_OFFSET);
  localparam logic [5:0] OFF_LO = 6'(LEN_OFFSET + 1);
  localparam logic [15:0] HEAD_LEN16 = 16'(HEAD_LEN);

  state_t state, state_next;
  logic [CNT_W-1:0] hcnt;
  logic [CNT_W-1:0] rd_cnt;
  logic pend;
  logic pend_last;
  logic only_header;
  logic [15:0] bytes_left;
  logic [15:0] max_len;
  logic [7:0] len_hi;
  logic [7:0] len_lo;
  logic [15:0] packet_length;

  logic in_acc;
  logic slot_free;
  logic move;
  logic issue;
  logic reject;
  logic body_last;
  logic load;
  result_t load_res;
  result_t res_out;
  logic [7:0] rdata;

  assign packet_length = {len_hi, len_lo};
  assign in_acc = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign reject = (packet_length < HEAD_LEN16) || (packet_length > max_len);
  assign body_last = (bytes_left == 16'd1);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_HUNT: begin
        if (in_acc && hcnt == CNT_LAST) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!reject) begin
          state_next = ST_REPLAY;
        end else if (slot_free) begin
          state_next = ST_HUNT;
        end
      end
      ST_REPLAY: begin
        if (rd_cnt == CNT_DONE && !pend) begin
          state_next = only_header ? ST_HUNT : ST_BODY;
        end
      end
      ST_BODY: begin
        if (in_acc && body_last) begin
          state_next = ST_HUNT;
        end
      end
      default: state_next = ST_HUNT;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    move = 1'b0;
    issue = 1'b0;
    load = 1'b0;
    load_res = '0;
    load_res.packet_length = packet_length;
    case (state)
      ST_HUNT: begin
        in_ready = 1'b1;
      end
      ST_CHECK: begin
        load = reject && slot_free;
        load_res.rejected = 1'b1;
      end
      ST_REPLAY: begin
        move = pend && slot_free;
        issue = (rd_cnt != CNT_DONE) && (!pend || move);
        load = move;
        load_res.data = rdata;
        load_res.is_header = 1'b1;
        load_res.last = pend_last;
      end
      ST_BODY: begin
        in_ready = slot_free;
        load = in_valid && slot_free;
        load_res.data = rx_byte;
        load_res.last = body_last;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT;
      hcnt <= '0;
      rd_cnt <= '0;
      pend <= 1'b0;
      pend_last <= 1'b0;
      only_header <= 1'b0;
      bytes_left <= '0;
      max_len <= MAX_LEN_RESET;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        max_len <= max_packet_length;
      end
      if (state == ST_HUNT && in_acc) begin
        hcnt <= (hcnt == CNT_LAST) ? '0 : hcnt + 1'b1;
      end
      if (state == ST_CHECK) begin
        rd_cnt <= '0;
        only_header <= (packet_length == HEAD_LEN16);
        bytes_left <= packet_length - HEAD_LEN16;
      end else if (issue) begin
        rd_cnt <= rd_cnt + 1'b1;
      end
      if (issue) begin
        pend <= 1'b1;
        pend_last <= only_header && (rd_cnt == CNT_LAST);
      end else if (move) begin
        pend <= 1'b0;
      end
      if (state == ST_BODY && in_acc) begin
        bytes_left <= bytes_left - 16'd1;
      end
    end
  end

  // length bytes captured as the header streams in
  always_ff @(posedge clk) begin
    if (state == ST_HUNT && in_acc) begin
      if (6'(hcnt) == OFF_HI) begin
        len_hi <= rx_byte;
      end
      if (6'(hcnt) == OFF_LO) begin
        len_lo <= rx_byte;
      end
    end
  end

  lpd_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_header_ram (
    .clk  (clk),
    .we   (state == ST_HUNT && in_acc),
    .waddr(STORE_AW'(hcnt)),
    .wdata(rx_byte),
    .re   (issue),
    .raddr(STORE_AW'(rd_cnt)),
    .rdata(rdata)
  );

  lpd_out_stage u_out_stage (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .res_in   (load_res),
    .free     (slot_free),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .res_out  (res_out)
  );

  assign out_byte = res_out.data;
  assign out_is_header = res_out.is_header;
  assign out_last = res_out.last;
  assign out_rejected = res_out.rejected;
  assign out_packet_length = res_out.packet_length;

`ifndef SYNTHESIS
  a_pend_in_replay: assert property (@(posedge clk) disable iff (rst)
    pend |-> state == ST_REPLAY)
    else $error("header read outstanding outside replay");

  a_body_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BODY && in_acc) |=> out_valid)
    else $error("body item gave no result");

  a_rd_cnt_range: assert property (@(posedge clk) disable iff (rst)
    rd_cnt <= CNT_DONE)
    else $error("replay counter past header length");

  a_no_input_in_replay: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK || state == ST_REPLAY) |-> !in_ready)
    else $error("input taken during check or replay");
`endif

endmodule
